@@ src/bamp_pkg.sv @@
// Package: shared constants and codes for the bitmask assignment max-profit block.
`timescale 1ns / 1ps
`default_nettype none
package bamp_pkg;

  // Default sizing of the problem tables
  localparam int MAX_PEOPLE_DEF = 6;
  localparam int MAX_TASKS_DEF  = 16;

  // Fixed field widths
  localparam int PROFIT_W  = 24;
  localparam int TOTAL_W   = 27;
  localparam int BASE_W    = 16;
  localparam int WEIGHT_W  = 8;
  localparam int PIN_W     = 3;
  localparam int TIN_W     = 4;
  localparam int TCNT_W    = 5;
  localparam int PCNT_W    = 3;
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 3;

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  // Register indexes (decoded from paddr[2])
  localparam logic REG_TASK_COUNT   = 1'b0;
  localparam logic REG_PERSON_COUNT = 1'b1;

endpackage
`default_nettype wire

@@ src/bamp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bamp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/bitmask_assignment_max_profit_top.sv @@
// Top level: profit table load, bitmask DP solve over people masks, APB config.
// Load word: accepted when start high, busy low; written at that edge if indices fit; no result.
// Solve word: walks masks full..0; a mask with work takes a popcount step, one memory read per
//   person (each memory has a single read port) and a write-back; a skipped mask just writes zero.
//   Result strobe is registered in the cycle after the final write-back.
// One word in flight at a time; the receiver cannot stall. Synchronous active-low reset
//   returns to idle with task_count = 1, person_count = 1; table contents undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module bitmask_assignment_max_profit_top #(
  parameter int MAX_PEOPLE = bamp_pkg::MAX_PEOPLE_DEF,
  parameter int MAX_TASKS  = bamp_pkg::MAX_TASKS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // command channel
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_command,
  input  wire logic [bamp_pkg::PIN_W-1:0]   in_person_index,
  input  wire logic [bamp_pkg::TIN_W-1:0]   in_task_index,
  input  wire logic [bamp_pkg::BASE_W-1:0]  in_base_profit,
  input  wire logic [bamp_pkg::WEIGHT_W-1:0] in_weight_multiplier,
  // result channel
  output logic                              out_valid,
  output logic [bamp_pkg::TOTAL_W-1:0]      out_best_total,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bamp_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [bamp_pkg::CFG_DW-1:0]  pwdata,
  output logic      [bamp_pkg::CFG_DW-1:0]  prdata,
  output logic                              pready
);

  localparam int PIDX_W  = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;
  localparam int TIDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int MASK_W  = MAX_PEOPLE;
  localparam int MASKS   = 1 << MAX_PEOPLE;
  localparam int USED_W  = $clog2(MAX_PEOPLE + 1);
  localparam int PADDR_W = PIDX_W + TIDX_W;
  localparam int PDEPTH  = 1 << PADDR_W;
  localparam int CMP_W   = 8;
  localparam logic REG_TASK_COUNT_C = bamp_pkg::REG_TASK_COUNT;

  typedef enum logic [1:0] {ST_IDLE, ST_MASK, ST_SCAN, ST_DRAIN} state_t;

  state_t                          state_r;
  logic [bamp_pkg::TCNT_W-1:0]     task_count_r;
  logic [bamp_pkg::PCNT_W-1:0]     person_count_r;
  logic [bamp_pkg::TCNT_W-1:0]     tasks_r;
  logic [bamp_pkg::PCNT_W-1:0]     people_r;
  logic [MASK_W-1:0]               mask_r;
  logic [MASK_W-1:0]               full_r;
  logic [PIDX_W-1:0]               i_r;
  logic                            take_r;
  logic [bamp_pkg::TOTAL_W-1:0]    best_r;
  logic [bamp_pkg::TOTAL_W-1:0]    best_nxt;
  logic                            out_valid_r;
  logic [bamp_pkg::TOTAL_W-1:0]    out_best_total_r;

  logic                            accept;
  logic                            load_ok;
  logic [USED_W-1:0]               used;
  logic                            skip;
  logic                            last_person;
  logic [bamp_pkg::TOTAL_W-1:0]    cand;

  // profit table ports
  logic                            prof_we;
  logic [PADDR_W-1:0]              prof_waddr;
  logic [bamp_pkg::PROFIT_W-1:0]   prof_wdata;
  logic [PADDR_W-1:0]              prof_raddr;
  logic [bamp_pkg::PROFIT_W-1:0]   prof_rdata;

  // best-by-mask ports
  logic                            best_we;
  logic [MASK_W-1:0]               best_waddr;
  logic [bamp_pkg::TOTAL_W-1:0]    best_wdata;
  logic [MASK_W-1:0]               best_raddr;
  logic [bamp_pkg::TOTAL_W-1:0]    best_rdata;

  logic                            cfg_wr;

  function automatic logic [USED_W-1:0] ones_in(input logic [MASK_W-1:0] v);
    logic [USED_W-1:0] c;
    c = '0;
    for (int k = 0; k < MASK_W; k++) begin
      c = c + USED_W'(v[k]);
    end
    return c;
  endfunction

  // handshake
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_best_total = out_best_total_r;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  always_comb begin
    unique case (paddr[2])
      REG_TASK_COUNT_C:   prdata = bamp_pkg::CFG_DW'(task_count_r);
      default:            prdata = bamp_pkg::CFG_DW'(person_count_r);
    endcase
  end

  // load path: weight the profit and write one table word
  assign load_ok    = (int'(in_person_index) < MAX_PEOPLE) && (int'(in_task_index) < MAX_TASKS);
  assign prof_we    = accept && (in_command == bamp_pkg::CMD_LOAD) && load_ok;
  assign prof_waddr = {PIDX_W'(in_person_index), TIDX_W'(in_task_index)};
  assign prof_wdata = in_base_profit * in_weight_multiplier;

  // per-mask control
  assign used = ones_in(mask_r);
  assign skip = (mask_r == full_r) || (CMP_W'(used) >= CMP_W'(tasks_r));
  assign last_person = (CMP_W'(i_r) == CMP_W'(people_r) - CMP_W'(1));

  // read requests: one person per cycle
  assign prof_raddr = {i_r, TIDX_W'(used)};
  assign best_raddr = mask_r | (MASK_W'(1) << i_r);

  // max accumulate on returned data
  assign cand     = bamp_pkg::TOTAL_W'(prof_rdata) + best_rdata;
  assign best_nxt = (take_r && (cand > best_r)) ? cand : best_r;

  // write-back of the mask's best
  always_comb begin
    best_we    = 1'b0;
    best_waddr = mask_r;
    best_wdata = '0;
    unique case (state_r)
      ST_MASK: begin
        best_we = skip;
      end
      ST_DRAIN: begin
        best_we    = 1'b1;
        best_wdata = best_nxt;
      end
      default: begin
        best_we = 1'b0;
      end
    endcase
  end

  bamp_ram #(.WIDTH(bamp_pkg::PROFIT_W), .DEPTH(PDEPTH)) u_profit_ram (
    .clk   (clk),
    .we    (prof_we),
    .waddr (prof_waddr),
    .wdata (prof_wdata),
    .raddr (prof_raddr),
    .rdata (prof_rdata)
  );

  bamp_ram #(.WIDTH(bamp_pkg::TOTAL_W), .DEPTH(MASKS)) u_best_ram (
    .clk   (clk),
    .we    (best_we),
    .waddr (best_waddr),
    .wdata (best_wdata),
    .raddr (best_raddr),
    .rdata (best_rdata)
  );

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      task_count_r   <= bamp_pkg::TCNT_W'(1);
      person_count_r <= bamp_pkg::PCNT_W'(1);
      out_valid_r    <= 1'b0;
      take_r         <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;

      if (cfg_wr) begin
        unique case (paddr[2])
          REG_TASK_COUNT_C: task_count_r   <= pwdata[bamp_pkg::TCNT_W-1:0];
          default:          person_count_r <= pwdata[bamp_pkg::PCNT_W-1:0];
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept && (in_command == bamp_pkg::CMD_SOLVE)) begin
            // clamp counts and start from the full mask
            if (int'(task_count_r) > MAX_TASKS) begin
              tasks_r <= bamp_pkg::TCNT_W'(MAX_TASKS);
            end else begin
              tasks_r <= task_count_r;
            end
            if (int'(person_count_r) > MAX_PEOPLE) begin
              people_r <= bamp_pkg::PCNT_W'(MAX_PEOPLE);
              mask_r   <= MASK_W'((32'd1 << MAX_PEOPLE) - 32'd1);
              full_r   <= MASK_W'((32'd1 << MAX_PEOPLE) - 32'd1);
            end else begin
              people_r <= person_count_r;
              mask_r   <= MASK_W'((32'd1 << person_count_r) - 32'd1);
              full_r   <= MASK_W'((32'd1 << person_count_r) - 32'd1);
            end
            state_r <= ST_MASK;
          end
        end
        ST_MASK: begin
          if (skip) begin
            // nothing to assign: best is zero, already written
            if (mask_r == '0) begin
              out_valid_r      <= 1'b1;
              out_best_total_r <= '0;
              state_r          <= ST_IDLE;
            end else begin
              mask_r <= mask_r - MASK_W'(1);
            end
          end else begin
            i_r     <= '0;
            best_r  <= '0;
            take_r  <= 1'b0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          best_r <= best_nxt;
          take_r <= !mask_r[i_r];
          if (last_person) begin
            state_r <= ST_DRAIN;
          end else begin
            i_r <= i_r + PIDX_W'(1);
          end
        end
        ST_DRAIN: begin
          take_r <= 1'b0;
          if (mask_r == '0) begin
            out_valid_r      <= 1'b1;
            out_best_total_r <= best_nxt;
            state_r          <= ST_IDLE;
          end else begin
            mask_r  <= mask_r - MASK_W'(1);
            state_r <= ST_MASK;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
